/* hdl/mhe_pkg.sv */
// Shared types and constants for the min-heap extract block.
`timescale 1ns / 1ps
package mhe_pkg;

  localparam int HeapDepthDefault = 16;
  localparam int ValueW           = 32;
  localparam int StatusW          = 2;
  localparam int CountOutW        = 5;

  // Command codes carried by the mode field.
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // Commands from the controller to the datapath, at most one set per cycle.
  typedef struct packed {
    logic load;       // append value at the heap end, or flag a full heap
    logic ext_empty;  // extract on an empty heap
    logic ext_start;  // read root and last entry, shrink the count
    logic ext_take;   // capture the root and the entry to sift
    logic lvl_read;   // read both children of the hole
    logic move;       // move the smaller child up into the hole
    logic fill;       // drop the sifted entry into the hole
  } mhe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic leaf;  // the hole has no child within the count
    logic stop;  // the sifted entry is not larger than the smaller child
  } mhe_stat_t;

endpackage

/* hdl/min_heap_extract_top.sv */
// Top level of the min-heap extract block.
//
//   Channel   Signals                                   Transaction taken when
//   command   start, busy, mode_i, value_i              start high and busy low at a rising edge
//   result    done_o, min_value_o, status_o,            done_o high: one cycle, cannot be held off
//             count_after_o
//
// A load takes one cycle: its result strobe shows in the next cycle, and busy stays low,
// so a new command may be taken in every cycle of a run of loads. An extract on an empty
// heap behaves the same way. A real extract first reads the root and the last entry,
// then captures them, then spends a read step and a compare step on each level that
// the entry moves down (a read of both children through the memory's two registered
// read ports, then a compare and one memory write). The entry is then placed in the
// hole directly when it has reached a leaf, or after one more read and compare
// when it stops above a child. The steps are paced by the single write port of the
// heap memory and its registered reads. Reset clears the entry count and the controller;
// the heap memory is not cleared, since only written entries are ever read.
// The receiver cannot stall, so a result is shown exactly once, in the cycle after the
// last step of its command, and a new command may be taken in that same cycle.
`timescale 1ns / 1ps
module min_heap_extract_top #(
  parameter int HEAP_DEPTH = mhe_pkg::HeapDepthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              mode_i,
  input  logic signed [mhe_pkg::ValueW-1:0] value_i,
  output logic                              done_o,
  output logic signed [mhe_pkg::ValueW-1:0] min_value_o,
  output logic [mhe_pkg::StatusW-1:0]       status_o,
  output logic [mhe_pkg::CountOutW-1:0]     count_after_o
);
  import mhe_pkg::*;

  // Commands flow down to the datapath; status flows back to the controller.
  mhe_cmd_t  cmd;
  mhe_stat_t stat;

  mhe_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .mode_i (mode_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  // The datapath holds the heap memory, the entry count, the hole position with the
  // entry being sifted, and the result registers that stay put between transactions.
  mhe_datapath #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .value_i       (value_i),
    .stat_o        (stat),
    .min_value_o   (min_value_o),
    .status_o      (status_o),
    .count_after_o (count_after_o)
  );

endmodule

/* hdl/mhe_ctrl.sv */
// Controller state machine of the min-heap extract block.
`timescale 1ns / 1ps
module mhe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              mode_i,
  input  mhe_pkg::mhe_stat_t stat_i,
  output mhe_pkg::mhe_cmd_t  cmd_o,
  output logic              busy,
  output logic              done_o
);
  import mhe_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_LVL_RD,
    S_LVL_CMP
  } state_e;

  state_e   state_q;
  state_e   state_d;
  logic     done_d;
  mhe_cmd_t cmd;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    done_d  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (mode_i == MODE_LOAD) begin
            cmd.load = 1'b1;
            done_d   = 1'b1;
          end else if (stat_i.empty) begin
            cmd.ext_empty = 1'b1;
            done_d        = 1'b1;
          end else begin
            cmd.ext_start = 1'b1;
            state_d       = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        cmd.ext_take = 1'b1;
        state_d      = S_LVL_RD;
      end
      S_LVL_RD: begin
        if (stat_i.leaf) begin
          cmd.fill = 1'b1;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          cmd.lvl_read = 1'b1;
          state_d      = S_LVL_CMP;
        end
      end
      S_LVL_CMP: begin
        if (stat_i.stop) begin
          cmd.fill = 1'b1;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          cmd.move = 1'b1;
          state_d  = S_LVL_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  logic busy_q;
  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
      done_q  <= done_d;
    end
  end

  assign cmd_o  = cmd;
  assign busy   = busy_q;
  assign done_o = done_q;

endmodule

/* hdl/mhe_datapath.sv */
// Datapath of the min-heap extract block: heap memory, count, hole and result registers.
`timescale 1ns / 1ps
module mhe_datapath #(
  parameter int HEAP_DEPTH = mhe_pkg::HeapDepthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mhe_pkg::mhe_cmd_t                 cmd_i,
  input  logic signed [mhe_pkg::ValueW-1:0] value_i,
  output mhe_pkg::mhe_stat_t                stat_o,
  output logic signed [mhe_pkg::ValueW-1:0] min_value_o,
  output logic [mhe_pkg::StatusW-1:0]       status_o,
  output logic [mhe_pkg::CountOutW-1:0]     count_after_o
);
  import mhe_pkg::*;

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int IW = AW + 2;

  logic signed [ValueW-1:0] mem [HEAP_DEPTH];
  logic signed [ValueW-1:0] rd_a_q;
  logic signed [ValueW-1:0] rd_b_q;
  logic [AW-1:0]            rd_addr_a;
  logic [AW-1:0]            rd_addr_b;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic signed [ValueW-1:0] wr_data;

  logic [CW-1:0]            count_q;
  logic [CW-1:0]            last_idx;
  logic [AW-1:0]            pos_q;
  logic signed [ValueW-1:0] x_q;
  logic signed [ValueW-1:0] min_q;
  status_e                  status_q;

  logic [IW-1:0]            left_w;
  logic [IW-1:0]            right_w;
  logic [IW-1:0]            count_x;
  logic                     full;
  logic                     use_right;
  logic [IW-1:0]            pick_w;
  logic signed [ValueW-1:0] child;

  assign full     = (count_q >= CW'(HEAP_DEPTH));
  assign last_idx = count_q - CW'(1);
  assign left_w   = {1'b0, pos_q, 1'b1};
  assign right_w  = {1'b0, pos_q, 1'b0} + IW'(2);
  assign count_x  = IW'(count_q);

  // The right child takes part only when it lies within the count; ties go left.
  assign use_right = (right_w < count_x) && (rd_b_q < rd_a_q);
  assign pick_w    = use_right ? right_w : left_w;
  assign child     = use_right ? rd_b_q : rd_a_q;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.leaf  = (left_w >= count_x);
  assign stat_o.stop  = (x_q <= child);

  always_comb begin
    if (cmd_i.ext_start) begin
      rd_addr_a = '0;
      rd_addr_b = last_idx[AW-1:0];
    end else begin
      rd_addr_a = left_w[AW-1:0];
      rd_addr_b = right_w[AW-1:0];
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_q;
    wr_data = x_q;
    priority if (cmd_i.load) begin
      wr_en   = !full;
      wr_addr = count_q[AW-1:0];
      wr_data = value_i;
    end else if (cmd_i.move) begin
      wr_en   = 1'b1;
      wr_data = child;
    end else if (cmd_i.fill) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_q <= mem[rd_addr_a];
    rd_b_q <= mem[rd_addr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      status_q <= STATUS_OK;
    end else begin
      if (cmd_i.load) begin
        status_q <= full ? STATUS_FULL : STATUS_OK;
        if (!full) begin
          count_q <= count_q + CW'(1);
        end
      end
      if (cmd_i.ext_empty) begin
        status_q <= STATUS_EMPTY;
      end
      if (cmd_i.ext_start) begin
        status_q <= STATUS_OK;
        count_q  <= last_idx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load || cmd_i.ext_empty) begin
      min_q <= '0;
    end
    if (cmd_i.ext_take) begin
      min_q <= rd_a_q;
      x_q   <= rd_b_q;
      pos_q <= '0;
    end
    if (cmd_i.move) begin
      pos_q <= pick_w[AW-1:0];
    end
  end

  logic [31:0] count_wide;
  assign count_wide    = 32'(count_q);
  assign count_after_o = count_wide[CountOutW-1:0];
  assign min_value_o   = min_q;
  assign status_o      = status_q;

endmodule

/* hdl/mhe_checker.sv */
// Port-level assertions for the min-heap extract block and their bind.
`timescale 1ns / 1ps
module mhe_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic                              done_o,
  input logic signed [mhe_pkg::ValueW-1:0] min_value_o,
  input logic [mhe_pkg::StatusW-1:0]       status_o
);
  import mhe_pkg::*;

  // A result strobe always comes with the block ready for the next transaction.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // An accepted transaction either completes at once or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted transaction neither busy nor done");

  // Each transaction gives one strobe: no second strobe without a new transaction.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !start) |=> !done_o)
    else $error("repeated result strobe");

  // The block leaves its busy phase only by delivering a result.
  a_busy_ends_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

  // Flagged transactions return a zero minimum.
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != STATUS_OK)) |-> (min_value_o == '0))
    else $error("flagged result carries a nonzero minimum");

endmodule

bind min_heap_extract_top mhe_checker u_mhe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .min_value_o (min_value_o),
  .status_o    (status_o)
);
